// File: rtl/core/fslt_pkg.sv
// Shared types, constants and register indexes of the four-sensor light tracker.
package fslt_pkg;

    // Field widths fixed by the interface.
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int MARGIN_W        = 10;
    localparam int STEP_W          = 10;
    localparam int POS_W           = 12;
    localparam int MOVE_W          = 3;
    localparam int LEVEL_OUT_W     = 10;
    localparam int THR_W           = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 12;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MARGIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AZ_STEP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EL_STEP  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AZ_MIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AZ_MAX   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_EL_MIN   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_EL_MAX   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [MARGIN_W-1:0] RST_MARGIN  = 10'd10;
    localparam logic [STEP_W-1:0]   RST_AZ_STEP = 10'd100;
    localparam logic [STEP_W-1:0]   RST_EL_STEP = 10'd100;
    localparam logic [POS_W-1:0]    RST_AZ_MIN  = 12'd600;
    localparam logic [POS_W-1:0]    RST_AZ_MAX  = 12'd2600;
    localparam logic [POS_W-1:0]    RST_EL_MIN  = 12'd600;
    localparam logic [POS_W-1:0]    RST_EL_MAX  = 12'd1300;

    // Reset positions of the two servos.
    localparam logic [POS_W-1:0] RST_AZ_POS = 12'd1600;
    localparam logic [POS_W-1:0] RST_EL_POS = 12'd1300;

    // Move codes reported with each result word.
    typedef enum logic [MOVE_W-1:0] {
        MOVE_NONE    = 3'd0,
        MOVE_EL_DOWN = 3'd1,
        MOVE_EL_UP   = 3'd2,
        MOVE_LEFT    = 3'd3,
        MOVE_RIGHT   = 3'd4
    } t_move;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [MARGIN_W-1:0] margin;
        logic [STEP_W-1:0]   az_step;
        logic [STEP_W-1:0]   el_step;
        logic [POS_W-1:0]    az_min;
        logic [POS_W-1:0]    az_max;
        logic [POS_W-1:0]    el_min;
        logic [POS_W-1:0]    el_max;
    } t_cfg;

endpackage

// File: rtl/core/fslt_cfg.sv
// Configuration register file of the light tracker.
module fslt_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fslt_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [fslt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output fslt_pkg::t_cfg                      o_cfg
);

    fslt_pkg::t_cfg r_cfg;

    // Write one register per enable; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.margin  <= fslt_pkg::RST_MARGIN;
            r_cfg.az_step <= fslt_pkg::RST_AZ_STEP;
            r_cfg.el_step <= fslt_pkg::RST_EL_STEP;
            r_cfg.az_min  <= fslt_pkg::RST_AZ_MIN;
            r_cfg.az_max  <= fslt_pkg::RST_AZ_MAX;
            r_cfg.el_min  <= fslt_pkg::RST_EL_MIN;
            r_cfg.el_max  <= fslt_pkg::RST_EL_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fslt_pkg::REG_MARGIN: begin
                    r_cfg.margin <= i_cfg_wdata[fslt_pkg::MARGIN_W-1:0];
                end
                fslt_pkg::REG_AZ_STEP: begin
                    r_cfg.az_step <= i_cfg_wdata[fslt_pkg::STEP_W-1:0];
                end
                fslt_pkg::REG_EL_STEP: begin
                    r_cfg.el_step <= i_cfg_wdata[fslt_pkg::STEP_W-1:0];
                end
                fslt_pkg::REG_AZ_MIN: begin
                    r_cfg.az_min <= i_cfg_wdata[fslt_pkg::POS_W-1:0];
                end
                fslt_pkg::REG_AZ_MAX: begin
                    r_cfg.az_max <= i_cfg_wdata[fslt_pkg::POS_W-1:0];
                end
                fslt_pkg::REG_EL_MIN: begin
                    r_cfg.el_min <= i_cfg_wdata[fslt_pkg::POS_W-1:0];
                end
                fslt_pkg::REG_EL_MAX: begin
                    r_cfg.el_max <= i_cfg_wdata[fslt_pkg::POS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/fslt_mean.sv
// Candidate reference levels: two-, three- and four-sensor means of one sample set.
module fslt_mean #(
    parameter int SAMPLE_BITS = fslt_pkg::DEF_SAMPLE_BITS
) (
    input  logic [SAMPLE_BITS-1:0] i_r0,
    input  logic [SAMPLE_BITS-1:0] i_r1,
    input  logic [SAMPLE_BITS-1:0] i_l1,
    input  logic [SAMPLE_BITS-1:0] i_l0,
    output logic [SAMPLE_BITS-1:0] o_mean4,
    output logic [SAMPLE_BITS-1:0] o_half_dn,
    output logic [SAMPLE_BITS-1:0] o_half_up,
    output logic [SAMPLE_BITS-1:0] o_third_l0,
    output logic [SAMPLE_BITS-1:0] o_third_l1,
    output logic [SAMPLE_BITS-1:0] o_third_r1,
    output logic [SAMPLE_BITS-1:0] o_third_r0
);

    // Sums of up to four samples need two extra bits.
    localparam int SUM_W  = SAMPLE_BITS + 2;
    // Reciprocal of three, rounded up; exact for every sum below 2**(SHIFT-1).
    localparam int SHIFT  = SUM_W + 2;
    localparam int PROD_W = SUM_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP3 = SHIFT'(((64'd1 << SHIFT) + 64'd2) / 64'd3);

    logic [SUM_W-1:0] s_half_dn;
    logic [SUM_W-1:0] s_half_up;
    logic [SUM_W-1:0] s_all;
    logic [SUM_W-1:0] s_no_l0;
    logic [SUM_W-1:0] s_no_l1;
    logic [SUM_W-1:0] s_no_r1;
    logic [SUM_W-1:0] s_no_r0;

    // Truncating divide by three through a constant multiply and shift.
    function automatic logic [SAMPLE_BITS-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP3);
        return SAMPLE_BITS'(p >> SHIFT);
    endfunction

    // Partial sums of the sensor groups.
    always_comb begin
        s_half_dn = SUM_W'(i_r0) + SUM_W'(i_l1);
        s_half_up = SUM_W'(i_r1) + SUM_W'(i_l0);
        s_all     = s_half_dn + s_half_up;
        s_no_l0   = s_half_dn + SUM_W'(i_r1);
        s_no_l1   = SUM_W'(i_l0) + SUM_W'(i_r0) + SUM_W'(i_r1);
        s_no_r1   = s_half_dn + SUM_W'(i_l0);
        s_no_r0   = s_half_up + SUM_W'(i_l1);
    end

    // Means; the halves and quarter are plain shifts.
    assign o_mean4    = SAMPLE_BITS'(s_all >> 2);
    assign o_half_dn  = SAMPLE_BITS'(s_half_dn >> 1);
    assign o_half_up  = SAMPLE_BITS'(s_half_up >> 1);
    assign o_third_l0 = div3(s_no_l0);
    assign o_third_l1 = div3(s_no_l1);
    assign o_third_r1 = div3(s_no_r1);
    assign o_third_r0 = div3(s_no_r0);

endmodule

// File: rtl/core/fslt_servo.sv
// One servo step: bound gating, signed step and clamping to the allowed range.
module fslt_servo (
    input  logic [fslt_pkg::POS_W-1:0]  i_pos,
    input  logic [fslt_pkg::STEP_W-1:0] i_step,
    input  logic                        i_up,
    input  logic [fslt_pkg::POS_W-1:0]  i_lo,
    input  logic [fslt_pkg::POS_W-1:0]  i_hi,
    output logic [fslt_pkg::POS_W-1:0]  o_pos
);

    localparam int EXT_W = fslt_pkg::POS_W + 2;

    logic                    go;
    logic                    step_nz;
    logic signed [EXT_W-1:0] pos_x;
    logic signed [EXT_W-1:0] step_x;
    logic signed [EXT_W-1:0] lo_x;
    logic signed [EXT_W-1:0] hi_x;
    logic signed [EXT_W-1:0] sum;
    logic signed [EXT_W-1:0] clamped;

    // A servo moves when strictly inside its bounds, or at a bound moving inward.
    always_comb begin
        step_nz = (i_step != '0);
        go = ((i_pos > i_lo) && (i_pos < i_hi))
            || ((i_pos == i_lo) && i_up && step_nz)
            || ((i_pos == i_hi) && !i_up && step_nz);
    end

    // Step in a signed range wide enough for both directions, then clamp.
    always_comb begin
        pos_x  = $signed(EXT_W'(i_pos));
        step_x = $signed(EXT_W'(i_step));
        lo_x   = $signed(EXT_W'(i_lo));
        hi_x   = $signed(EXT_W'(i_hi));
        sum    = i_up ? (pos_x + step_x) : (pos_x - step_x);
        clamped = sum;
        if (clamped > hi_x) begin
            clamped = hi_x;
        end
        if (clamped < lo_x) begin
            clamped = lo_x;
        end
        o_pos = go ? fslt_pkg::POS_W'(clamped) : i_pos;
    end

endmodule

// File: rtl/core/four_sensor_light_tracker_servo_stepper_unit.sv
// Top level of the four-sensor light tracker with azimuth and elevation servo stepping.
//
// Input channel: one word is a set of four light samples (right outer, right inner,
// left inner, left outer), taken when i_valid and o_ready are both high.
// Output channel: one result word per input word: both servo pulse widths after the
// step, the move code and the new reference level, taken when o_valid and i_ready
// are both high.
// Configuration: i_cfg_we writes i_cfg_wdata into the register at i_cfg_addr at the
// clock edge; write only while no word is in flight.
// Order: an accepted word passes the sample register, then the result register.
// Throughput: one word per cycle unless stalled. The sample register feeds the means,
// threshold tests and servo steps into the result register, which holds the reference
// level and servo positions, so each word sees the state left by the word before it.
// Reset: synchronous, active low; both stages empty, the reference level goes to
// zero and the servos to their home positions, and the registers to their defaults.
// Stall: when i_ready is low the result word holds; o_ready drops only once the
// sample register is full as well.
module four_sensor_light_tracker_servo_stepper_unit #(
    parameter int SAMPLE_BITS = fslt_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fslt_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [fslt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [SAMPLE_BITS-1:0]              i_right_outer,
    input  logic [SAMPLE_BITS-1:0]              i_right_inner,
    input  logic [SAMPLE_BITS-1:0]              i_left_inner,
    input  logic [SAMPLE_BITS-1:0]              i_left_outer,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fslt_pkg::POS_W-1:0]          o_azimuth_pulse,
    output logic [fslt_pkg::POS_W-1:0]          o_elevation_pulse,
    output logic [fslt_pkg::MOVE_W-1:0]         o_move_taken,
    output logic [fslt_pkg::LEVEL_OUT_W-1:0]    o_reference_out
);

    fslt_pkg::t_cfg cfg;

    // Stage one: sample register.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_r0;
    logic [SAMPLE_BITS-1:0] r_in_r1;
    logic [SAMPLE_BITS-1:0] r_in_l1;
    logic [SAMPLE_BITS-1:0] r_in_l0;

    logic [SAMPLE_BITS-1:0] mean4;
    logic [SAMPLE_BITS-1:0] half_dn;
    logic [SAMPLE_BITS-1:0] half_up;
    logic [SAMPLE_BITS-1:0] third_l0;
    logic [SAMPLE_BITS-1:0] third_l1;
    logic [SAMPLE_BITS-1:0] third_r1;
    logic [SAMPLE_BITS-1:0] third_r0;

    // Stage two: result register, which is also the tracker state.
    logic                        r_out_valid;
    logic [SAMPLE_BITS-1:0]      r_level;
    logic [fslt_pkg::POS_W-1:0]  r_az;
    logic [fslt_pkg::POS_W-1:0]  r_el;
    fslt_pkg::t_move             r_move;

    logic [SAMPLE_BITS-1:0]      n_level;
    logic [fslt_pkg::POS_W-1:0]  n_az;
    logic [fslt_pkg::POS_W-1:0]  n_el;
    fslt_pkg::t_move             n_move;

    logic                        out_en;
    logic                        in_en;
    logic [fslt_pkg::THR_W-1:0]  thr;
    logic                        dark_r0;
    logic                        dark_r1;
    logic                        dark_l1;
    logic                        dark_l0;
    logic                        az_move;
    logic                        el_move;
    logic [fslt_pkg::POS_W-1:0]  az_next;
    logic [fslt_pkg::POS_W-1:0]  el_next;

    fslt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Pipeline advance: each stage moves when the one after it can take a word.
    assign out_en  = !r_out_valid || i_ready;
    assign in_en   = !r_in_valid || out_en;
    assign o_ready = in_en;

    // Sample register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_valid) begin
            r_in_r0 <= i_right_outer;
            r_in_r1 <= i_right_inner;
            r_in_l1 <= i_left_inner;
            r_in_l0 <= i_left_outer;
        end
    end

    fslt_mean #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean (
        .i_r0       (r_in_r0),
        .i_r1       (r_in_r1),
        .i_l1       (r_in_l1),
        .i_l0       (r_in_l0),
        .o_mean4    (mean4),
        .o_half_dn  (half_dn),
        .o_half_up  (half_up),
        .o_third_l0 (third_l0),
        .o_third_l1 (third_l1),
        .o_third_r1 (third_r1),
        .o_third_r0 (third_r0)
    );

    // Darkness threshold wraps in 16 bits when the margin exceeds the level.
    always_comb begin
        thr     = fslt_pkg::THR_W'(r_level) - fslt_pkg::THR_W'(cfg.margin);
        dark_r0 = fslt_pkg::THR_W'(r_in_r0) < thr;
        dark_r1 = fslt_pkg::THR_W'(r_in_r1) < thr;
        dark_l1 = fslt_pkg::THR_W'(r_in_l1) < thr;
        dark_l0 = fslt_pkg::THR_W'(r_in_l0) < thr;
    end

    // Fixed-priority move choice; a zero level only takes the four-sensor mean.
    always_comb begin
        n_move  = fslt_pkg::MOVE_NONE;
        n_level = mean4;
        if (r_level != '0) begin
            if (dark_l0 && dark_r0) begin
                n_move  = fslt_pkg::MOVE_EL_DOWN;
                n_level = half_dn;
            end else if (dark_l1 && dark_r1) begin
                n_move  = fslt_pkg::MOVE_EL_UP;
                n_level = half_up;
            end else if (dark_l0) begin
                n_move  = fslt_pkg::MOVE_LEFT;
                n_level = third_l0;
            end else if (dark_l1) begin
                n_move  = fslt_pkg::MOVE_LEFT;
                n_level = third_l1;
            end else if (dark_r1) begin
                n_move  = fslt_pkg::MOVE_RIGHT;
                n_level = third_r1;
            end else if (dark_r0) begin
                n_move  = fslt_pkg::MOVE_RIGHT;
                n_level = third_r0;
            end
        end
        az_move = (n_move == fslt_pkg::MOVE_LEFT) || (n_move == fslt_pkg::MOVE_RIGHT);
        el_move = (n_move == fslt_pkg::MOVE_EL_DOWN) || (n_move == fslt_pkg::MOVE_EL_UP);
    end

    fslt_servo u_az_servo (
        .i_pos  (r_az),
        .i_step (cfg.az_step),
        .i_up   (n_move == fslt_pkg::MOVE_RIGHT),
        .i_lo   (cfg.az_min),
        .i_hi   (cfg.az_max),
        .o_pos  (az_next)
    );

    fslt_servo u_el_servo (
        .i_pos  (r_el),
        .i_step (cfg.el_step),
        .i_up   (n_move == fslt_pkg::MOVE_EL_UP),
        .i_lo   (cfg.el_min),
        .i_hi   (cfg.el_max),
        .o_pos  (el_next)
    );

    // Only the servo named by the move steps; the other holds.
    assign n_az = az_move ? az_next : r_az;
    assign n_el = el_move ? el_next : r_el;

    // Result register and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= '0;
            r_az        <= fslt_pkg::RST_AZ_POS;
            r_el        <= fslt_pkg::RST_EL_POS;
            r_move      <= fslt_pkg::MOVE_NONE;
        end else if (out_en) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_level <= n_level;
                r_az    <= n_az;
                r_el    <= n_el;
                r_move  <= n_move;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_azimuth_pulse   = r_az;
    assign o_elevation_pulse = r_el;
    assign o_move_taken      = r_move;
    assign o_reference_out   = fslt_pkg::LEVEL_OUT_W'(r_level);

endmodule

// File: rtl/core/fslt_checker.sv
// Port-level checks of the light tracker, attached to the top level by bind.
module fslt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_ready,
    input logic                             o_valid,
    input logic                             o_ready,
    input logic [fslt_pkg::POS_W-1:0]       o_azimuth_pulse,
    input logic [fslt_pkg::POS_W-1:0]       o_elevation_pulse,
    input logic [fslt_pkg::MOVE_W-1:0]      o_move_taken,
    input logic [fslt_pkg::LEVEL_OUT_W-1:0] o_reference_out
);

    // A stalled result word holds all of its fields.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_azimuth_pulse)
            && $stable(o_elevation_pulse) && $stable(o_move_taken)
            && $stable(o_reference_out)))
        else $error("result word changed while stalled");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The input side only backs up behind a full, stalled output.
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input not ready without a stalled result");

    // Move codes stay within the defined set.
    a_move_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_move_taken == fslt_pkg::MOVE_NONE)
            || (o_move_taken == fslt_pkg::MOVE_EL_DOWN)
            || (o_move_taken == fslt_pkg::MOVE_EL_UP)
            || (o_move_taken == fslt_pkg::MOVE_LEFT)
            || (o_move_taken == fslt_pkg::MOVE_RIGHT)))
        else $error("undefined move code");

endmodule

bind four_sensor_light_tracker_servo_stepper_unit fslt_checker u_fslt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_ready           (i_ready),
    .o_valid           (o_valid),
    .o_ready           (o_ready),
    .o_azimuth_pulse   (o_azimuth_pulse),
    .o_elevation_pulse (o_elevation_pulse),
    .o_move_taken      (o_move_taken),
    .o_reference_out   (o_reference_out)
);
